/* rtl/core/ascending_array_sorter_assert.svh */
// Assertion macros for the ascending array sorter.
`ifndef ASCENDING_ARRAY_SORTER_ASSERT_SVH
`define ASCENDING_ARRAY_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define ASRT_CHECK(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("sorter check failed");
// Antecedent in one cycle implies consequent in the next cycle.
`define ASRT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sorter sequence check failed");
`else
`define ASRT_CHECK(lbl, clk_s, rstn_s, cond)
`define ASRT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

/* rtl/core/asrt_pkg.sv */
// Shared types and constants for the ascending array sorter.
`timescale 1ns / 1ps
`default_nettype none
package asrt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the new value at its sorted place
    logic shift;  // move every value one cell toward the head
  } cell_ctl_t;

  // Handshake and flag status from the controller.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic last_out;
    logic overflow;
  } ctrl_status_t;

endpackage
`default_nettype wire

/* rtl/core/asrt_cell.sv */
// One compare-and-hold cell of the sorting chain.
`timescale 1ns / 1ps
`default_nettype none
module asrt_cell (
  input  logic                                clk,
  input  asrt_pkg::cell_ctl_t                 ctl,
  input  logic signed [asrt_pkg::DATA_W-1:0]  new_value,
  input  logic                                occ,
  input  logic                                left_occ,
  input  logic                                left_take,
  input  logic signed [asrt_pkg::DATA_W-1:0]  left_value,
  input  logic signed [asrt_pkg::DATA_W-1:0]  right_value,
  output logic                                take,
  output logic signed [asrt_pkg::DATA_W-1:0]  value
);

  logic signed [asrt_pkg::DATA_W-1:0] value_r;
  logic signed [asrt_pkg::DATA_W-1:0] value_nxt;

  // A strictly greater stored value yields its place, so equal values keep arrival order.
  assign take  = occ && (value_r > new_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.shift) begin
      value_nxt = right_value;
    end else if (ctl.ins) begin
      if (left_take) begin
        value_nxt = left_value;
      end else if (take || (!occ && left_occ)) begin
        value_nxt = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/asrt_ctrl.sv */
// Load and drain sequencer with fill count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module asrt_ctrl #(
  parameter int DEPTH = asrt_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  input  logic                   out_ready,
  output asrt_pkg::cell_ctl_t    ctl,
  output asrt_pkg::ctrl_status_t status,
  output logic [CNT_W-1:0]       fill_count
);

  asrt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asrt_pkg::ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    ovf_nxt          = ovf_r;
    ctl              = '0;
    status.in_ready  = 1'b0;
    status.out_valid = 1'b0;
    status.last_out  = (cnt_r == CNT_W'(1));
    status.overflow  = ovf_r;
    unique case (state_r)
      asrt_pkg::ST_LOAD: begin
        status.in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CNT_W'(DEPTH)) begin
            ctl.ins = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = asrt_pkg::ST_DRAIN;
          end
        end
      end
      asrt_pkg::ST_DRAIN: begin
        status.out_valid = 1'b1;
        if (out_ready) begin
          ctl.shift = 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = asrt_pkg::ST_LOAD;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = asrt_pkg::ST_LOAD;
      end
    endcase
  end

  assign fill_count = cnt_r;

endmodule
`default_nettype wire

/* rtl/core/ascending_array_sorter.sv */
// Top level of the ascending array sorter: insertion chain of compare cells.
//
//  Channel | Ports               | Payload
//  --------+---------------------+-------------------------------------------
//  in      | in_tvalid/in_tready | in_tdata = value, in_tlast = last of set
//  out     | out_tvalid/tready   | out_tdata = sorted_value, out_tlast =
//          |                     | last_out, out_tuser = overflow
//
// While a set loads, one request is taken every cycle; each value is placed at
// its sorted position in the same cycle by the row of DEPTH compare cells.
// After the last request of a set the block drains N results at up to one per
// cycle (N = stored count), shifting the chain toward its head; no input is
// taken while draining. Requests beyond DEPTH are still taken, but dropped.
// Output stalls hold the head cell and the counter. Reset is synchronous,
// active low, clears the controller only and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ascending_array_sorter #(
  parameter int DEPTH = asrt_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value (signed)
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  asrt_pkg::cell_ctl_t    ctl;
  asrt_pkg::ctrl_status_t status;
  logic [CNT_W-1:0]       fill_count;

  logic signed [asrt_pkg::DATA_W-1:0] new_value;
  logic signed [asrt_pkg::DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]                   take;
  logic [DEPTH-1:0]                   occ;

  assign new_value = in_tdata;

  asrt_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_last    (in_tlast),
    .out_ready  (out_tready),
    .ctl        (ctl),
    .status     (status),
    .fill_count (fill_count)
  );

  // Cells below the fill count hold values in ascending order from the head.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                               left_occ;
      logic                               left_take;
      logic signed [asrt_pkg::DATA_W-1:0] left_value;
      logic signed [asrt_pkg::DATA_W-1:0] right_value;

      assign occ[gi] = (fill_count > CNT_W'(gi));

      if (gi == 0) begin : g_head
        // The head has an always occupied, never yielding neighbor on its left.
        assign left_occ   = 1'b1;
        assign left_take  = 1'b0;
        assign left_value = new_value;
      end else begin : g_body
        assign left_occ   = occ[gi-1];
        assign left_take  = take[gi-1];
        assign left_value = cell_val[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_value = cell_val[gi];
      end else begin : g_mid
        assign right_value = cell_val[gi+1];
      end

      asrt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .new_value   (new_value),
        .occ         (occ[gi]),
        .left_occ    (left_occ),
        .left_take   (left_take),
        .left_value  (left_value),
        .right_value (right_value),
        .take        (take[gi]),
        .value       (cell_val[gi])
      );
    end
  endgenerate

  // Results are read straight from the head cell.
  assign in_tready  = status.in_ready;
  assign out_tvalid = status.out_valid;
  assign out_tdata  = cell_val[0];
  assign out_tlast  = status.last_out;
  assign out_tuser  = status.overflow;

`include "ascending_array_sorter_assert.svh"

  // Loading and draining never overlap.
  `ASRT_CHECK(a_no_overlap, clk, rst_n, !(in_tready && out_tvalid))
  // A drain always has at least one stored value behind it.
  `ASRT_CHECK(a_drain_nonempty, clk, rst_n, !out_tvalid || (fill_count != '0))
  // The last request of a set starts the drain in the next cycle.
  `ASRT_NEXT(a_last_starts_drain, clk, rst_n, in_tvalid && in_tready && in_tlast,
             out_tvalid && (fill_count != '0))
  // Taking the final result returns the block to loading with an empty chain.
  `ASRT_NEXT(a_final_reloads, clk, rst_n, out_tvalid && out_tready && out_tlast,
             in_tready && (fill_count == '0) && !out_tuser)

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the ascending array sorter, with stream-level stimulus and prediction.
`timescale 1ns / 1ps

// Sets of signed values go in on the input stream, and each set is closed by
// tlast. Every accepted request is fed into a behavioral sorter that keeps the
// set in ascending order, with equal values in arrival order. When a set
// closes, that sorter queues the results it expects: every kept value, in order,
// with tlast on the largest and the set's overflow flag on all of them. A
// checker process pops one expectation per accepted result and compares the
// fields. Both sides idle at random. One phase holds the receiver off long
// enough that the block backs up into its input. Another phase lets the
// sender drain the block completely before it goes on.
module tb_top;

  localparam int SET_MAX  = asrt_pkg::DEPTH_DEF;
  localparam int DRAIN_GAP = 4 * SET_MAX;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_rslt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // Behavioral copy of the sorter state: kept values of the open set, in order.
  logic signed [31:0] held_vals[$];
  bit                 held_ovf;
  // Results owed by the block, oldest first.
  sorted_rslt_t       sorted_due[$];

  int  fail_count = 0;
  int  items_sent = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  rx_hold_req = 0;
  bit  rx_holding = 1'b0;

  ascending_array_sorter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin : clk_gen
    forever #1 clk = ~clk;
  end

  // Take one accepted request into the behavioral sorter. A full store drops
  // the value and marks the set. When tlast arrives, the whole set is queued
  // as expected results, and the sorter starts over empty.
  function automatic void sorter_absorb(logic signed [31:0] v, logic closes_set);
    int pos;
    pos = 0;
    if (held_vals.size() < SET_MAX) begin
      while (pos < held_vals.size() && held_vals[pos] <= v) pos++;
      held_vals.insert(pos, v);
    end else begin
      held_ovf = 1'b1;
    end
    if (closes_set) begin
      foreach (held_vals[k])
        sorted_due.push_back('{value: held_vals[k],
                               last:  (k == held_vals.size() - 1),
                               ovf:   held_ovf});
      held_vals.delete();
      held_ovf = 1'b0;
    end
  endfunction

  function automatic void note_failure(string what);
    if (fail_count < 10) $display("tb_top: mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endfunction

  // Both monitors read the values that stood before the edge, so they see the
  // same request and result as the block does.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sorter_absorb(in_tdata, in_tlast);
  end

  always @(posedge clk) begin : result_check
    sorted_rslt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_due.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                               $signed(out_tdata), out_tlast, out_tuser));
      end else begin
        want = sorted_due.pop_front();
        if (out_tdata !== want.value || out_tlast !== want.last || out_tuser !== want.ovf)
          note_failure($sformatf("expected value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                                 want.value, want.last, want.ovf,
                                 $signed(out_tdata), out_tlast, out_tuser));
      end
    end
  end

  // Receiver: random stalls, with runs of steady acceptance in between. A hold
  // request from a test turns into one long stall, counted here in cycles.
  initial begin : rx_flow
    int n;
    forever begin
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        rx_holding = 1'b1;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        rx_holding = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offer one request and return at the edge that accepts it. Valid stays high
  // on return, so back-to-back requests keep it up with no glitch. Only an idle
  // gap lowers it, and a caller that waits between requests lowers it first.
  task automatic push_element(logic [31:0] v, logic closes_set);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= closes_set;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Random element: half the time full-range values, often a narrow band so that
  // duplicates occur, and sometimes the ends of the signed range, minus one or zero.
  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return 32'($signed($urandom_range(0, 15)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic push_set(int len);
    for (int i = 0; i < len; i++) push_element(pick_element(), i == len - 1);
  endtask

  // Wait until the block has delivered everything it owes, then let it settle.
  task automatic wait_drained();
    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // A set of one, then a set that covers both signed ends, zero and minus one,
  // with duplicates among them.
  task automatic test_extremes();
    push_element(32'h8000_0000, 1'b1);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b0);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'h0000_0005, 1'b0);
    push_element(32'h0000_0001, 1'b1);
  endtask

  // Seventeen requests in descending order, with duplicates. The store fills
  // on the sixteenth, so the closing request itself is dropped and every
  // result carries overflow.
  task automatic test_overflow_on_last();
    for (int i = 0; i < SET_MAX + 1; i++)
      push_element(32'(SET_MAX / 2 - i / 2), i == SET_MAX);
  endtask

  task automatic test_random_sets(int n_items);
    int len;
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(SET_MAX + 1, SET_MAX + 8)
                                        : $urandom_range(1, SET_MAX);
      push_set(len);
    end
  endtask

  // Stall the receiver for a long stretch while a full set and a further set
  // are offered. The block holds its drain and has to push back on the input.
  task automatic test_output_stall();
    in_tvalid <= 1'b0;
    rx_hold_req = 300;
    @(posedge clk);
    while (!rx_holding) @(posedge clk);
    push_set(SET_MAX);
    push_set(10);
  endtask

  // Let the block empty out completely before the sender goes on.
  task automatic test_sender_pause();
    push_set($urandom_range(2, SET_MAX));
    in_tvalid <= 1'b0;
    wait_drained();
    push_set($urandom_range(SET_MAX + 1, SET_MAX + 5));
  endtask

  initial begin : timeout
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_overflow_on_last();
    test_random_sets(60);
    test_output_stall();
    test_sender_pause();
    test_random_sets(40);

    // The closing stretch runs with no idling on either side.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_sets(40);

    in_tvalid <= 1'b0;
    wait_drained();
    if (fail_count == 0 && sorted_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
